// ----- rtl/ieq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ieq_pkg
// Shared types and constants for the interrupt event queue.
// ----------------------------------------------------------------------------
package ieq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;

    localparam int VEC_W     = 8;
    localparam int ERR_W     = 32;
    localparam int FILL_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;
    localparam int ENTRY_W   = VEC_W + ERR_W;

    // Vectors at or above this number have no bit in the exception mask.
    localparam int MASK_VECTORS = 32;

    localparam logic [VEC_W-1:0] SPURIOUS_RESET = 8'd39;
    localparam logic [CFG_W-1:0] MASK_RESET     = 32'h0000_6D40;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPURIOUS_VECTOR = 1'b0,
        REG_EXCEPTION_MASK  = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_QUEUED    = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_SPURIOUS  = 3'd2,
        ST_FATAL     = 3'd3,
        ST_DELIVERED = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_HALTED    = 3'd6
    } status_t;

    typedef enum logic {
        MODE_RAISE = 1'b0,
        MODE_POP   = 1'b1
    } mode_t;

endpackage : ieq_pkg
`default_nettype wire

// ----- rtl/ieq_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ieq_store
// Event storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ieq_store #(
    parameter int DEPTH = ieq_pkg::QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [ieq_pkg::ENTRY_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               rd_addr,
    output logic      [ieq_pkg::ENTRY_W-1:0] rd_data
);
    import ieq_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read, so it can sit on the output.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : ieq_store
`default_nettype wire

// ----- rtl/interrupt_event_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// interrupt_event_queue
// Interrupt raise filter with a ring buffer of pending events and a halt flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (s_*) either raise an interrupt (mode 0) or pop the oldest
//   queued event (mode 1). Each input word produces exactly one result word
//   on the m_* channel carrying a status, the popped or fatal vector and
//   error word, and the fill level after the item.
//   The result is valid in the cycle after the input word is accepted; one
//   word per cycle is sustained while the receiver takes each result. On a
//   pop the output is driven by the registered read data of the single read
//   port of the event store, which is issued in the same cycle as the accept.
//   When the receiver stalls, the result is held and s_ready stays low until
//   the result is taken; a result taken in the same cycle frees the slot.
//   Reset clears the pointers, the halt flag and the output valid, and loads
//   the register defaults; the event store itself is not cleared, entries
//   are only read after being written. The configuration channel is always
//   ready and should be written only while the block is idle.
//   A fatal vector halts the block; every later word reports halted until
//   reset.
// ----------------------------------------------------------------------------
module interrupt_event_queue #(
    parameter int QUEUE_DEPTH = ieq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ieq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ieq_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_mode,
    input  wire logic [ieq_pkg::VEC_W-1:0]     s_vector,
    input  wire logic [ieq_pkg::ERR_W-1:0]     s_error_word,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [2:0]                    m_status,
    output logic      [ieq_pkg::VEC_W-1:0]     m_out_vector,
    output logic      [ieq_pkg::ERR_W-1:0]     m_out_error,
    output logic      [ieq_pkg::FILL_W-1:0]    m_fill_level
);
    import ieq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(QUEUE_DEPTH);

    logic [VEC_W-1:0]  spurious_reg, spurious_next;
    logic [CFG_W-1:0]  mask_reg, mask_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic              halted_reg, halted_next;
    logic              m_valid_reg, m_valid_next;
    status_t           status_reg, status_next;
    logic [VEC_W-1:0]  vec_reg, vec_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              from_mem_reg, from_mem_next;

    logic              s_accept;
    logic              is_fatal;
    logic              is_full;
    logic              is_empty;
    logic [AW-1:0]     tail_inc;
    logic [AW-1:0]     head_inc;
    logic [AW:0]       diff;
    logic [AW:0]       count;
    logic              wr_en;
    logic              rd_en;
    logic [ENTRY_W-1:0] rd_data;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;

    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign is_full  = (tail_inc == head_reg);
    assign is_empty = (head_reg == tail_reg);
    assign is_fatal = (s_vector < VEC_W'(MASK_VECTORS)) && mask_reg[s_vector[4:0]];

    always_comb begin
        spurious_next = spurious_reg;
        mask_next     = mask_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_SPURIOUS_VECTOR: spurious_next = cfg_data[VEC_W-1:0];
                REG_EXCEPTION_MASK:  mask_next     = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        halted_next   = halted_reg;
        status_next   = status_reg;
        vec_next      = vec_reg;
        err_next      = err_reg;
        from_mem_next = from_mem_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        m_valid_next  = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept) begin
            m_valid_next  = 1'b1;
            vec_next      = '0;
            err_next      = '0;
            from_mem_next = 1'b0;
            if (halted_reg) begin
                status_next = ST_HALTED;
            end else if (mode_t'(s_mode) == MODE_RAISE) begin
                if (s_vector == spurious_reg) begin
                    status_next = ST_SPURIOUS;
                end else if (is_fatal) begin
                    status_next = ST_FATAL;
                    halted_next = 1'b1;
                    vec_next    = s_vector;
                    err_next    = s_error_word;
                end else if (is_full) begin
                    status_next = ST_DROPPED;
                end else begin
                    status_next = ST_QUEUED;
                    wr_en       = 1'b1;
                    tail_next   = tail_inc;
                end
            end else begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    // The store read lands at the same edge as the result.
                    status_next   = ST_DELIVERED;
                    rd_en         = 1'b1;
                    from_mem_next = 1'b1;
                    head_next     = head_inc;
                end
            end
        end
    end

    // Fill level after the item, from the updated pointers.
    assign diff  = {1'b0, tail_next} - {1'b0, head_next};
    assign count = (tail_next >= head_next) ? diff : diff + DEPTH_EXT;

    always_comb begin
        fill_next = fill_reg;
        if (s_accept) begin
            fill_next = FILL_W'(count);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spurious_reg <= SPURIOUS_RESET;
            mask_reg     <= MASK_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            halted_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            spurious_reg <= spurious_next;
            mask_reg     <= mask_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            halted_reg   <= halted_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        vec_reg      <= vec_next;
        err_reg      <= err_next;
        fill_reg     <= fill_next;
        from_mem_reg <= from_mem_next;
    end

    ieq_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data ({s_vector, s_error_word}),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_out_vector = from_mem_reg ? rd_data[ENTRY_W-1:ERR_W] : vec_reg;
    assign m_out_error  = from_mem_reg ? rd_data[ERR_W-1:0] : err_reg;
    assign m_fill_level = fill_reg;

    // Pointers always stay inside the ring.
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg <= LAST_SLOT) && (tail_reg <= LAST_SLOT))
        else $error("queue pointer outside the ring");

    // The halt flag is sticky until reset.
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    // Any word accepted while halted reports halted.
    a_halt_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && halted_reg) |=> (m_valid && m_status == ST_HALTED))
        else $error("word accepted while halted did not report halted");

    // A pop from an empty queue reports empty and leaves the head alone.
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !halted_reg && s_mode && is_empty)
        |=> (m_status == ST_EMPTY && $stable(head_reg)))
        else $error("pop from empty queue misreported");

endmodule : interrupt_event_queue
`default_nettype wire
